// ===== design/etsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etsd_pkg;

  localparam int unsigned COUNT_W = 13;
  localparam int unsigned BYTES_W = 15;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_TRUNCATED     = 3'd1,
    ERR_VARINT_OVF    = 3'd2,
    ERR_BAD_RUN       = 3'd3,
    ERR_ZERO_QUANTUM  = 3'd4,
    ERR_BAD_TAG       = 3'd5,
    ERR_INCONSISTENT  = 3'd6,
    ERR_OVERSIZED     = 3'd7
  } err_code_t;

  localparam logic [7:0] TAG_ZERO_RUN = 8'd0;
  localparam logic [7:0] TAG_QUANTUM  = 8'd1;

  localparam logic [2:0] VARINT_LAST_IDX = 3'd4;
  localparam logic [2:0] VARINT_MAX_LEN  = 3'd5;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0]  quantum;
    logic [COUNT_W-1:0]  repeat_count;
    logic                stream_done;
    logic [2:0]          error_code;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== design/error_token_stream_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one byte per cycle when no result is held; the byte step is a single
// registered pass (input register -> varint/tag logic -> result register).
// Stall from the result side reaches in_stall only when a result must be held.
// Reset (rst_n low, synchronous) clears the stream state, the sticky error
// and both valid flags; expected_count returns to 1.
module error_token_stream_decoder
  import etsd_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_beat,

  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_beat,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [COUNT_W-1:0] exp_count_r;
  logic               cfg_wr;
  logic               cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr == 3'd0);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {{(32-COUNT_W){1'b0}}, exp_count_r} : 32'd0;

  // Effective count, clamped to MAX_COUNT
  logic [COUNT_W-1:0] count;
  logic [31:0]        count_wide;
  assign count = ({{(32-COUNT_W){1'b0}}, exp_count_r} > 32'(MAX_COUNT)) ?
                 COUNT_W'(MAX_COUNT) : exp_count_r;
  assign count_wide = {{(32-COUNT_W){1'b0}}, count};

  // Byte budget: count*7 + 2, at most 57339, so 16 bits
  logic [15:0] byte_limit;
  assign byte_limit = ({3'b0, count} << 3) - {3'b0, count} + 16'd2;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic     st_valid_r;
  in_beat_t st_beat_r;
  logic     st_adv;
  logic     out_free;
  logic     emit;

  assign out_free = !out_valid || !out_stall;
  // The stage moves on unless it holds a result with nowhere to go.
  assign st_adv   = !emit || out_free;
  assign in_stall = st_valid_r && !st_adv;

  // ---------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------
  logic                in_varint_r, in_varint_nxt;
  logic [7:0]          tag_r, tag_nxt;
  logic [31:0]         accum_r, accum_nxt;
  logic [2:0]          idx_r, idx_nxt;
  // Full width: a zero run may carry the total far past a count that was
  // lowered mid-stream, and the end check compares the whole value.
  logic [31:0]         produced_r, produced_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic                err_r, err_nxt;

  out_beat_t           res;
  logic [BYTES_W-1:0]  bytes_inc;
  logic [31:0]         acc_new;
  logic [31:0]         acc_part;
  logic [31:0]         owed;
  logic [COUNT_W-1:0]  rep;
  logic [31:0]         rep_wide;
  logic [31:0]         produced_sum;
  logic signed [31:0]  q;
  logic [7:0]          b;
  logic                lst;
  logic                fail;
  logic [2:0]          fail_code;

  assign b   = st_beat_r.token_byte;
  assign lst = st_beat_r.last_byte;

  assign bytes_inc = (bytes_r == {BYTES_W{1'b1}}) ? bytes_r : bytes_r + 1'b1;

  // Seven payload bits placed by byte position; the fifth byte only keeps
  // its low nibble, the rest is rejected as overflow.
  always_comb begin
    case (idx_r)
      3'd0:    acc_part = {25'd0, b[6:0]};
      3'd1:    acc_part = {18'd0, b[6:0], 7'd0};
      3'd2:    acc_part = {11'd0, b[6:0], 14'd0};
      3'd3:    acc_part = {4'd0, b[6:0], 21'd0};
      3'd4:    acc_part = {b[3:0], 28'd0};
      default: acc_part = 32'd0;
    endcase
  end

  assign acc_new = accum_r | acc_part;
  assign owed    = count_wide - produced_r;

  always_comb begin
    in_varint_nxt = in_varint_r;
    tag_nxt       = tag_r;
    accum_nxt     = accum_r;
    idx_nxt       = idx_r;
    produced_nxt  = produced_r;
    bytes_nxt     = bytes_r;
    err_nxt       = err_r;
    emit          = 1'b0;
    fail          = 1'b0;
    fail_code     = ERR_OK;
    q             = 32'sd0;
    rep           = '0;
    rep_wide      = '0;
    produced_sum  = produced_r;
    res           = '0;

    if (st_valid_r && !err_r) begin
      bytes_nxt = bytes_inc;
      if ({1'b0, bytes_inc} > byte_limit) begin
        fail      = 1'b1;
        fail_code = ERR_OVERSIZED;
      end else if (!in_varint_r) begin
        // Tag byte
        if (produced_r >= count_wide) begin
          fail      = 1'b1;
          fail_code = ERR_INCONSISTENT;
        end else if (lst) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          tag_nxt       = b;
          in_varint_nxt = 1'b1;
          accum_nxt     = '0;
          idx_nxt       = '0;
        end
      end else if (idx_r >= VARINT_LAST_IDX && b[7:4] != 4'd0) begin
        fail      = 1'b1;
        fail_code = ERR_VARINT_OVF;
      end else begin
        accum_nxt = acc_new;
        if (b[7]) begin
          // Continuation
          if (lst) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else if (idx_r + 3'd1 >= VARINT_MAX_LEN) begin
            fail      = 1'b1;
            fail_code = ERR_VARINT_OVF;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          // Token complete
          in_varint_nxt = 1'b0;
          idx_nxt       = '0;
          if (tag_r == TAG_ZERO_RUN) begin
            rep_wide = acc_new;
            if (acc_new == 32'd0 || acc_new > owed) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_RUN;
            end
          end else if (tag_r == TAG_QUANTUM) begin
            rep_wide = 32'd1;
            q        = {1'b0, acc_new[31:1]} ^ {32{acc_new[0]}};
            if (acc_new == 32'd0) begin
              fail      = 1'b1;
              fail_code = ERR_ZERO_QUANTUM;
            end
          end else begin
            fail      = 1'b1;
            fail_code = ERR_BAD_TAG;
          end
          rep          = rep_wide[COUNT_W-1:0];
          produced_sum = produced_r + rep_wide;

          if (!fail) begin
            produced_nxt = produced_sum;
            if (lst) begin
              if (produced_sum != count_wide) begin
                fail      = 1'b1;
                fail_code = ERR_INCONSISTENT;
              end else begin
                // Clean end: a new stream may follow
                in_varint_nxt    = 1'b0;
                tag_nxt          = '0;
                accum_nxt        = '0;
                idx_nxt          = '0;
                produced_nxt     = '0;
                bytes_nxt        = '0;
                emit             = 1'b1;
                res.quantum      = q;
                res.repeat_count = rep;
                res.stream_done  = 1'b1;
                res.error_code   = ERR_OK;
              end
            end else begin
              emit             = 1'b1;
              res.quantum      = q;
              res.repeat_count = rep;
              res.stream_done  = 1'b0;
              res.error_code   = ERR_OK;
            end
          end
        end
      end

      if (fail) begin
        err_nxt          = 1'b1;
        emit             = 1'b1;
        res.quantum      = 32'sd0;
        res.repeat_count = '0;
        res.stream_done  = 1'b1;
        res.error_code   = fail_code;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic      out_valid_r;
  out_beat_t out_beat_r;
  logic      st_fire;

  // Stream state advances only when the staged byte leaves the stage.
  assign st_fire   = st_valid_r && st_adv;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_count_r <= COUNT_W'(1);
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      in_varint_r <= 1'b0;
      tag_r       <= '0;
      accum_r     <= '0;
      idx_r       <= '0;
      produced_r  <= '0;
      bytes_r     <= '0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        exp_count_r <= pwdata[COUNT_W-1:0];
      end
      if (!in_stall) begin
        st_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= st_fire && emit;
      end
      if (st_fire) begin
        in_varint_r <= in_varint_nxt;
        tag_r       <= tag_nxt;
        accum_r     <= accum_nxt;
        idx_r       <= idx_nxt;
        produced_r  <= produced_nxt;
        bytes_r     <= bytes_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      st_beat_r <= in_beat;
    end
    if (out_free && st_fire && emit) begin
      out_beat_r <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("sticky error flag cleared without reset");

  a_err_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.error_code != ERR_OK) |-> out_beat_r.stream_done)
    else $error("error beat without stream_done");

  a_err_beat_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.error_code != ERR_OK) |-> err_r)
    else $error("error beat shown but error not latched");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_varint_r |-> (idx_r == 3'd0))
    else $error("varint byte index nonzero while expecting a tag");

endmodule

`default_nettype wire

// ===== bench/error_token_stream_decoder_test.sv =====
`timescale 1ns / 1ps

module error_token_stream_decoder_test
  import etsd_pkg::*;
();

  localparam int unsigned COUNT_CAP      = 4096;
  localparam logic [2:0]  COUNT_ADDR     = 3'd0;   // expected_count register
  localparam int unsigned ITEMS_TARGET   = 500;
  localparam int unsigned SQUEEZE_AT     = 150;    // beats before the long hold-off
  localparam int unsigned SQUEEZE_CYCLES = 48;
  localparam int unsigned SETTLE_CYCLES  = 6;      // extra wait once nothing is owed
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned IDLE_LIMIT     = 1000;

  // Tracks the token decode state and holds the results the block still owes.
  class token_decode_tracker;
    out_beat_t   pending_quanta[$];
    int unsigned mismatches;
    int unsigned cap;
    logic [12:0] count_reg;
    bit          in_varint;
    logic [7:0]  tag;
    logic [31:0] accum;
    int unsigned vidx;
    int unsigned produced;
    int unsigned bytes_seen;
    bit          latched;

    function new(int unsigned cap_in);
      cap        = cap_in;
      count_reg  = 13'd1;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      in_varint  = 1'b0;
      tag        = 8'd0;
      accum      = 32'd0;
      vidx       = 0;
      produced   = 0;
      bytes_seen = 0;
      latched    = 1'b0;
    endfunction

    function void set_count(logic [12:0] value);
      count_reg = value;
    endfunction

    function void push(logic [31:0] q, logic [31:0] rep, logic done, err_code_t err);
      out_beat_t r;
      r.quantum      = q;
      r.repeat_count = rep[12:0];
      r.stream_done  = done;
      r.error_code   = err;
      pending_quanta = {pending_quanta, r};
    endfunction

    // Error beat: zero payload, marks stream end, and nothing follows.
    function void fail(err_code_t err);
      latched = 1'b1;
      push(32'd0, 32'd0, 1'b1, err);
    endfunction

    function void take_byte(in_beat_t beat);
      int unsigned cnt;
      logic [31:0] part;
      logic [31:0] owed;
      logic [31:0] q;
      logic [31:0] rep;
      cnt = (count_reg > cap) ? cap : count_reg;
      if (latched) return;
      if (bytes_seen < 32767) bytes_seen++;
      if (bytes_seen > cnt * 7 + 2) begin
        fail(ERR_OVERSIZED);
        return;
      end
      // tag position
      if (!in_varint) begin
        if (produced >= cnt) fail(ERR_INCONSISTENT);
        else if (beat.last_byte) fail(ERR_TRUNCATED);
        else begin
          tag       = beat.token_byte;
          in_varint = 1'b1;
          accum     = 32'd0;
          vidx      = 0;
        end
        return;
      end
      // varint byte; fifth byte may only carry the top four value bits
      if (vidx >= VARINT_LAST_IDX && beat.token_byte[7:4] != 4'd0) begin
        fail(ERR_VARINT_OVF);
        return;
      end
      if (vidx < VARINT_MAX_LEN) begin
        part  = {25'd0, beat.token_byte[6:0]};
        accum = accum | (part << (7 * vidx));
      end
      if (beat.token_byte[7]) begin
        if (beat.last_byte) begin
          fail(ERR_TRUNCATED);
          return;
        end
        vidx++;
        if (vidx >= VARINT_MAX_LEN) fail(ERR_VARINT_OVF);
        return;
      end
      in_varint = 1'b0;
      vidx      = 0;
      owed      = cnt - produced;   // wraps if the count was lowered mid-stream
      if (tag == TAG_ZERO_RUN) begin
        if (accum == 0 || accum > owed) begin
          fail(ERR_BAD_RUN);
          return;
        end
        q   = 32'd0;
        rep = accum;
      end else if (tag == TAG_QUANTUM) begin
        if (accum == 0) begin
          fail(ERR_ZERO_QUANTUM);
          return;
        end
        q   = (accum >> 1) ^ {32{accum[0]}};   // zigzag
        rep = 32'd1;
      end else begin
        fail(ERR_BAD_TAG);
        return;
      end
      produced += rep;
      if (beat.last_byte) begin
        if (produced != cnt) begin
          fail(ERR_INCONSISTENT);
          return;
        end
        clear_stream();
        push(q, rep, 1'b1, ERR_OK);
      end else begin
        push(q, rep, 1'b0, ERR_OK);
      end
    endfunction

    function void check_quantum(out_beat_t got);
      out_beat_t want;
      if (pending_quanta.size() == 0) begin
        $error("result with nothing pending: quantum %0d repeat_count %0d error_code %0d",
               got.quantum, got.repeat_count, got.error_code);
        mismatches++;
        return;
      end
      want = pending_quanta.pop_front();
      if (got.quantum !== want.quantum) begin
        $error("quantum: expected %0d, got %0d", want.quantum, got.quantum);
        mismatches++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
        mismatches++;
      end
      if (got.stream_done !== want.stream_done) begin
        $error("stream_done: expected %0d, got %0d", want.stream_done, got.stream_done);
        mismatches++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  token_decode_tracker board = new(COUNT_CAP);
  int unsigned bytes_taken = 0;
  int unsigned bad_reads = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;     // random idling on both channels
  bit          squeeze_req = 1'b0; // asks the receiver for one long hold-off

  always #6 clk = ~clk;

  error_token_stream_decoder #(
    .MAX_COUNT(COUNT_CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Watchdog: any beat, on either channel or the register port, counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick next cycle's stall.
  // A squeeze request turns into one long hold-off counted here, so the
  // block backs up and has to stall the sender.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_quantum(out_beat);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SQUEEZE_CYCLES;
      end else if (hold_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 4);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One token byte; optional idle burst first, then hold until accepted.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    in_beat_t beat;
    beat.token_byte = value;
    beat.last_byte  = is_last;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    board.take_byte(beat);
    bytes_taken++;
  endtask

  function automatic int unsigned varint_min_len(logic [31:0] v);
    int unsigned n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // Mostly minimal encodings; now and then padded out with zero groups.
  function automatic int unsigned pick_len(logic [31:0] v);
    int unsigned n;
    n = varint_min_len(v);
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 5);
    return n;
  endfunction

  task automatic send_varint(input logic [31:0] v, input int unsigned len, input logic is_last);
    logic [31:0] chunk;
    logic        more;
    for (int unsigned i = 0; i < len; i++) begin
      chunk = (i < 5) ? (v >> (7 * i)) : 32'd0;
      more  = (i + 1 < len);
      send_byte({more, chunk[6:0]}, is_last && !more);
    end
  endtask

  task automatic send_token(input logic [7:0] tag, input logic [31:0] v, input logic is_last);
    send_byte(tag, 1'b0);
    send_varint(v, pick_len(v), is_last);
  endtask

  function automatic logic [31:0] random_coded();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(1, 15);
      1: v = $urandom_range(1, 255);
      2: v = $urandom();
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'd1;
          1: v = 32'd2;
          2: v = 32'hffff_ffff;
          default: v = 32'hffff_fffe;
        endcase
      end
      default: v = $urandom_range(1, 16383);
    endcase
    if (v == 0) v = 32'd1;
    return v;
  endfunction

  // Well-formed tokens adding up to total quanta; last flag on the final
  // byte only when finish is set.
  task automatic send_stream(input int unsigned total, input bit finish);
    int unsigned left;
    int unsigned run;
    left = total;
    while (left > 0) begin
      if ($urandom_range(0, (left > 16) ? 3 : 1) == 0) begin
        send_token(TAG_QUANTUM, random_coded(), finish && left == 1);
        left--;
      end else begin
        run = $urandom_range(1, left);
        send_token(TAG_ZERO_RUN, run, finish && run == left);
        left -= run;
      end
    end
  endtask

  // Drop valid, let owed results drain, then leave time for byte beats that
  // produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_quanta.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Count write with junk in the unused upper bits, then read it back.
  task automatic write_count(input logic [12:0] value);
    logic [31:0] word;
    logic [31:0] readback;
    settle();
    word       = $urandom();
    word[12:0] = value;
    apb_write(COUNT_ADDR, word);
    board.set_count(value);
    apb_read(COUNT_ADDR, readback);
    if (readback[12:0] !== value) begin
      $error("expected_count readback: expected %0d, got %0d", value, readback[12:0]);
      bad_reads++;
    end
  endtask

  // Ends the run with one broken stream; an error latches for good, so only
  // one kind can be seen per run and the seed picks which.
  task automatic break_stream();
    err_code_t   kind;
    int unsigned c;
    int unsigned k;
    logic [31:0] v;
    kind = err_code_t'($urandom_range(1, 7));
    case (kind)
      ERR_TRUNCATED: begin
        write_count(13'($urandom_range(1, 20)));
        if ($urandom_range(0, 1) == 0) begin
          send_byte(TAG_QUANTUM, 1'b1);              // last flag on a tag
        end else begin
          send_byte(TAG_QUANTUM, 1'b0);
          send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b1);  // last with more pending
        end
      end
      ERR_VARINT_OVF: begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
        send_byte(8'($urandom_range(16, 255)), 1'($urandom_range(0, 1)));
      end
      ERR_BAD_RUN: begin
        c = $urandom_range(1, 20);
        write_count(13'(c));
        k = $urandom_range(0, c - 1);
        send_stream(k, 1'b0);
        v = ($urandom_range(0, 1) == 0) ? 32'd0 : (c - k) + $urandom_range(1, 300);
        send_byte(TAG_ZERO_RUN, 1'b0);
        send_varint(v, pick_len(v), 1'($urandom_range(0, 1)));
      end
      ERR_ZERO_QUANTUM: begin
        send_byte(TAG_QUANTUM, 1'b0);
        send_varint(32'd0, $urandom_range(1, 5), 1'($urandom_range(0, 1)));
      end
      ERR_BAD_TAG: begin
        v = $urandom();
        send_byte(8'($urandom_range(2, 255)), 1'b0);
        send_varint(v, pick_len(v), 1'($urandom_range(0, 1)));
      end
      ERR_INCONSISTENT: begin
        case ($urandom_range(0, 2))
          0: begin                                   // count of zero
            write_count(13'd0);
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          1: begin                                   // tag after the count is met
            c = $urandom_range(1, 20);
            write_count(13'(c));
            send_stream(c, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          default: begin                             // stream ends short
            c = $urandom_range(2, 20);
            write_count(13'(c));
            send_stream($urandom_range(0, c - 2), 1'b0);
            send_token(TAG_QUANTUM, random_coded(), 1'b1);
          end
        endcase
      end
      default: begin
        // Oversized: twelve bytes under a large count, then shrink the count
        // so the byte budget is already blown.
        write_count(13'd4096);
        repeat (2) begin
          send_byte(TAG_QUANTUM, 1'b0);
          send_varint(random_coded(), 5, 1'b0);
        end
        write_count(13'($urandom_range(0, 1)));
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    endcase
    // Anything after a latched error must be swallowed silently.
    repeat ($urandom_range(8, 16)) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [12:0] cfg;
    logic [31:0] readback;
    int unsigned eff;
    bit          squeezed;
    squeezed = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    apb_read(COUNT_ADDR, readback);
    if (readback[12:0] !== 13'd1) begin
      $error("expected_count after reset: expected 1, got %0d", readback[12:0]);
      bad_reads++;
    end

    // Directed: most negative quantum from a full five-byte varint (count 1).
    send_byte(TAG_QUANTUM, 1'b0);
    send_varint(32'hffff_ffff, 5, 1'b1);

    // Most positive quantum, minus one, padded one-quanta run.
    write_count(13'd3);
    send_byte(TAG_QUANTUM, 1'b0);
    send_varint(32'hffff_fffe, 5, 1'b0);
    send_token(TAG_QUANTUM, 32'd1, 1'b0);
    send_byte(TAG_ZERO_RUN, 1'b0);
    send_varint(32'd1, 2, 1'b1);

    // Largest run in one token.
    write_count(13'd4096);
    send_byte(TAG_ZERO_RUN, 1'b0);
    send_varint(32'd4096, 2, 1'b1);

    // Count above the cap behaves as the cap.
    write_count(13'd8191);
    send_byte(TAG_ZERO_RUN, 1'b0);
    send_varint(32'd4095, 2, 1'b0);
    send_token(TAG_QUANTUM, 32'd2, 1'b1);

    // Random streams with random counts, extremes included.
    while (bytes_taken < ITEMS_TARGET) begin
      case ($urandom_range(0, 9))
        0: cfg = 13'd1;
        1: cfg = 13'd4096;
        2: cfg = 13'd8191;
        3: cfg = 13'($urandom_range(4097, 8191));
        4: cfg = 13'($urandom_range(1, 4096));
        default: cfg = 13'($urandom_range(2, 24));
      endcase
      write_count(cfg);
      eff = (cfg > COUNT_CAP) ? COUNT_CAP : 32'(cfg);
      repeat ($urandom_range(1, 3)) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        send_stream(eff, 1'b1);
      end
      gaps_on = 1'b1;

      if (!squeezed && bytes_taken >= SQUEEZE_AT) begin
        // Sender keeps pushing with no gaps while the receiver holds off.
        squeezed = 1'b1;
        write_count(13'd40);
        gaps_on     = 1'b0;
        squeeze_req = 1'b1;
        send_stream(40, 1'b1);
        gaps_on = 1'b1;
      end
    end

    // Closing part: no idling, one clean stream, then one broken stream.
    gaps_on = 1'b0;
    cfg = 13'($urandom_range(1, 24));
    write_count(cfg);
    send_stream(32'(cfg), 1'b1);
    break_stream();

    in_valid <= 1'b0;
    while (board.pending_quanta.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && bad_reads == 0 && board.pending_quanta.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
